// ===== hdl/cosd_pkg.sv =====
// Package for the CoAP option stream decoder: item types, parse phase and
// event codes, and the running option number width. No dependencies.
`timescale 1ns / 1ps

package cosd_pkg;

   // width of the running option number; the result shows its low 16 bits
   localparam int NumberWidth = 16;

   localparam logic [3:0] LenEscape  = 4'hF;
   localparam logic [7:0] NibbleMask = 8'h0F;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_EXT    = 2'd1,
      PH_VALUE  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      EV_EXT_PENDING = 2'd0,
      EV_HEADER      = 2'd1,
      EV_VALUE       = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       message_start;
   } req_type;

   typedef struct packed {
      kind_type   event_kind;
      logic [15:0] option_number;
      logic [8:0]  option_length;
      logic [7:0]  value_byte;
      logic        value_last;
   } rsp_type;

endpackage

// ===== hdl/coap_option_stream_decoder.sv =====
// Top level of the CoAP option stream decoder: byte parser and result register.
// Depends on cosd_pkg.
`timescale 1ns / 1ps

// Takes one byte of a CoAP options region per cycle and returns exactly one
// result item per byte, in the cycle after the byte is accepted. The parse state
// (phase, running option number, remaining value bytes, current length) is
// updated in the accepting cycle by a nibble add and a counter step, so a
// byte can be accepted on every cycle; the only thing that holds the input
// back is a result still waiting in the output register while rsp_stall is
// high (req_stall follows rsp_stall in that case). message_start clears the
// running option number and abandons any unfinished option.
module coap_option_stream_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cosd_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cosd_pkg::rsp_type rsp_item
);

   localparam int NumberWidth = cosd_pkg::NumberWidth;

   cosd_pkg::phase_type      phase_ff, phase_in, phase_eff;
   logic [NumberWidth-1:0]   number_ff, number_in, number_eff;
   logic [8:0]               left_ff, left_in, left_eff, left_dec;
   logic [8:0]               length_ff, length_in;
   logic                     out_valid_ff, out_valid_in;
   cosd_pkg::rsp_type        rsp_ff, rsp_in;
   logic                     accept;
   logic [3:0]               len_nib;
   logic [NumberWidth+15:0]  number_ext;

   assign req_stall = out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cosd_pkg::PH_HEADER;
         number_ff    <= '0;
         left_ff      <= '0;
         length_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         number_ff    <= number_in;
         left_ff      <= left_in;
         length_ff    <= length_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      // start flag aborts whatever option was in progress
      phase_eff  = req_item.message_start ? cosd_pkg::PH_HEADER : phase_ff;
      number_eff = req_item.message_start ? '0 : number_ff;
      left_eff   = req_item.message_start ? 9'd0 : left_ff;
      left_dec   = (left_eff != 9'd0) ? left_eff - 9'd1 : 9'd0;
      len_nib    = 4'(req_item.in_byte & cosd_pkg::NibbleMask);

      phase_in  = phase_eff;
      number_in = number_eff;
      left_in   = left_eff;
      length_in = length_ff;

      rsp_in            = '0;
      rsp_in.event_kind = cosd_pkg::EV_EXT_PENDING;

      unique case (phase_eff)
         cosd_pkg::PH_EXT: begin
            length_in         = 9'(cosd_pkg::LenEscape) + {1'b0, req_item.in_byte};
            left_in           = length_in;
            phase_in          = cosd_pkg::PH_VALUE;
            rsp_in.event_kind = cosd_pkg::EV_HEADER;
         end
         cosd_pkg::PH_VALUE: begin
            rsp_in.event_kind = cosd_pkg::EV_VALUE;
            rsp_in.value_byte = req_item.in_byte;
            left_in           = left_dec;
            if (left_dec == 9'd0) begin
               rsp_in.value_last = 1'b1;
               phase_in          = cosd_pkg::PH_HEADER;
            end
         end
         default: begin
            number_in = number_eff + NumberWidth'(req_item.in_byte[7:4]);
            length_in = {5'd0, len_nib};
            if (len_nib == cosd_pkg::LenEscape) begin
               phase_in          = cosd_pkg::PH_EXT;
               left_in           = 9'd0;
               rsp_in.event_kind = cosd_pkg::EV_EXT_PENDING;
            end else begin
               rsp_in.event_kind = cosd_pkg::EV_HEADER;
               left_in           = {5'd0, len_nib};
               if (len_nib == 4'd0) begin
                  rsp_in.value_last = 1'b1;
                  phase_in          = cosd_pkg::PH_HEADER;
               end else begin
                  phase_in = cosd_pkg::PH_VALUE;
               end
            end
         end
      endcase

      number_ext           = {16'd0, number_in};
      rsp_in.option_number = number_ext[15:0];
      rsp_in.option_length = length_in;

      if (!accept) begin
         phase_in  = phase_ff;
         number_in = number_ff;
         left_in   = left_ff;
         length_in = length_ff;
      end

      out_valid_in = accept || (out_valid_ff && rsp_stall);
   end

endmodule

// ===== hdl/cosd_checker.sv =====
// Port-level checker for the CoAP option stream decoder, bound to the top level.
// Depends on cosd_pkg and coap_option_stream_decoder.
`timescale 1ns / 1ps

module cosd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cosd_pkg::rsp_type rsp_item
);

   // a waiting result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // every accepted byte yields a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item gave no result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.event_kind == cosd_pkg::EV_EXT_PENDING |->
         rsp_item.option_length == 9'd15 && !rsp_item.value_last &&
         rsp_item.value_byte == 8'd0)
      else $error("bad extension-pending result");

   // a header marked last must carry zero length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.event_kind == cosd_pkg::EV_HEADER && rsp_item.value_last |->
         rsp_item.option_length == 9'd0)
      else $error("header marked last with nonzero length");

endmodule

bind coap_option_stream_decoder cosd_checker u_cosd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
